// ----- rtl/onl_pkg.sv -----
// ----------------------------------------------------------------------------
// onl_pkg
// Types, codes and helper functions shared by the operator and number lexer.
// ----------------------------------------------------------------------------
package onl_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int MAX_DECIMALS = 9;
    localparam int POS_BITS     = 32;
    localparam int LEN_BITS     = 16;
    localparam int PLACES_BITS  = 4;
    localparam int KIND_BITS    = 4;
    localparam int CHAR_BITS    = 8;
    localparam int PROD_BITS    = VALUE_BITS + 4;

    localparam int QDEPTH       = 4;
    localparam int QPTR_BITS    = $clog2(QDEPTH);
    localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

    localparam int IN_DATA_BITS  = 8;
    localparam int IN_USER_BITS  = 1;
    localparam int OUT_DATA_BITS = 128;
    localparam int OUT_USER_BITS = KIND_BITS;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {VALUE_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]   LEN_MAX    = {LEN_BITS{1'b1}};
    localparam logic [PLACES_BITS-1:0] DEC_LIMIT = PLACES_BITS'(MAX_DECIMALS);

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_OP   = 4'b0010,
        MODE_INT  = 4'b0100,
        MODE_REAL = 4'b1000
    } mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_CHAR = 4'd0,
        KIND_AND  = 4'd1,
        KIND_OR   = 4'd2,
        KIND_EQ   = 4'd3,
        KIND_NE   = 4'd4,
        KIND_LE   = 4'd5,
        KIND_GE   = 4'd6,
        KIND_INT  = 4'd7,
        KIND_REAL = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CHAR_BITS-1:0]   char_code;
        logic [VALUE_BITS-1:0]  value;
        logic [PLACES_BITS-1:0] decimal_places;
        logic                   overflow;
        logic [POS_BITS-1:0]    start_offset;
        logic [LEN_BITS-1:0]    length;
        logic [POS_BITS-1:0]    line;
        logic                   last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return (c == CH_AMP) || (c == CH_BAR) || (c == CH_EQ) ||
               (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
    endfunction

    // kind of a two-byte operator, or KIND_CHAR when the pair does not fold
    function automatic kind_t pair_kind(input logic [7:0] first, input logic [7:0] second);
        kind_t k;
        k = KIND_CHAR;
        if (first == CH_AMP && second == CH_AMP)
            k = KIND_AND;
        else if (first == CH_BAR && second == CH_BAR)
            k = KIND_OR;
        else if (second == CH_EQ)
        begin
            if (first == CH_EQ)
                k = KIND_EQ;
            else if (first == CH_BANG)
                k = KIND_NE;
            else if (first == CH_LT)
                k = KIND_LE;
            else if (first == CH_GT)
                k = KIND_GE;
        end
        return k;
    endfunction

endpackage

// ----- rtl/operator_and_number_lexer.sv -----
// ----------------------------------------------------------------------------
// operator_and_number_lexer
// Byte-stream scanner for operators, single characters and decimal numbers.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per cycle while s_tready is high and
// reports tokens on the master side. An accepted word updates the scan state
// at once and pushes zero, one or two tokens into a four-entry result queue,
// read out in order. Input runs at one word per cycle as long as the queue
// holds at most two tokens, so with m_tready high the sustained rate is one
// word per cycle when words average one token or fewer, and one token per
// cycle is the ceiling set by the single output port. Numbers come out as a
// decimal mantissa plus a count of fractional digits, saturating with an
// overflow flag; an end-of-input word flushes a pending token.
module operator_and_number_lexer
    import onl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // ch
    input  logic [IN_USER_BITS-1:0]  s_tuser,   // end_of_input
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // char_code, value, decimal_places,
                                                // overflow, start_offset, length, line
    output logic [OUT_USER_BITS-1:0] m_tuser,   // kind
    output logic                     m_tlast
);

    // scan state
    mode_t                  mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [POS_BITS-1:0]    lines_reg, lines_next;
    logic [POS_BITS-1:0]    tstart_reg, tstart_next;
    logic [POS_BITS-1:0]    tline_reg, tline_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [PLACES_BITS-1:0] frac_reg, frac_next;
    logic                   sat_reg, sat_next;
    logic [LEN_BITS-1:0]    tlen_reg, tlen_next;

    // result queue
    token_t                 q_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]   cnt_reg;

    logic                   in_fire, out_fire;
    logic [7:0]             c;
    logic                   eoi;
    logic                   do_flush, do_begin;
    logic [PROD_BITS-1:0]   prod;
    logic [1:0]             n_tok;
    token_t                 tok0, tok1;
    token_t                 flush_tok, char_tok;
    logic                   flush_has, char_has;
    token_t                 head;

    assign c        = s_tdata[7:0];
    assign eoi      = s_tuser[0];
    assign s_tready = (cnt_reg <= QCNT_BITS'(QDEPTH - 2));
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // accumulator times ten plus digit, just wide enough that the saturation test never wraps
    assign prod = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                  PROD_BITS'(c - CH_ZERO);

    // token that a flush of the current mode gives
    always_comb
    begin
        flush_tok                = '0;
        flush_tok.start_offset   = tstart_reg;
        flush_tok.line           = tline_reg;
        flush_has                = 1'b0;
        case (mode_reg)
            MODE_OP:
            begin
                flush_has           = 1'b1;
                flush_tok.kind      = KIND_CHAR;
                flush_tok.char_code = pend_reg;
                flush_tok.length    = LEN_BITS'(1);
            end
            MODE_INT, MODE_REAL:
            begin
                flush_has                = 1'b1;
                flush_tok.kind           = (mode_reg == MODE_INT) ? KIND_INT : KIND_REAL;
                flush_tok.value          = acc_reg;
                flush_tok.decimal_places = (mode_reg == MODE_INT) ? '0 : frac_reg;
                flush_tok.overflow       = sat_reg;
                flush_tok.length         = tlen_reg;
            end
            default:
            begin
                flush_has = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        pos_next    = pos_reg;
        lines_next  = lines_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        acc_next    = acc_reg;
        frac_next   = frac_reg;
        sat_next    = sat_reg;
        tlen_next   = tlen_reg;
        do_flush    = 1'b0;
        do_begin    = 1'b0;
        char_has    = 1'b0;
        char_tok    = '0;
        tok0        = '0;
        tok1        = '0;
        n_tok       = 2'd0;

        if (eoi)
        begin
            do_flush = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            case (mode_reg)
                MODE_OP:
                begin
                    if (pair_kind(pend_reg, c) != KIND_CHAR)
                    begin
                        char_has              = 1'b1;
                        char_tok.kind         = pair_kind(pend_reg, c);
                        char_tok.start_offset = tstart_reg;
                        char_tok.length       = LEN_BITS'(2);
                        char_tok.line         = tline_reg;
                        mode_next             = MODE_IDLE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                MODE_INT, MODE_REAL:
                begin
                    if (is_digit(c))
                    begin
                        if (mode_reg == MODE_INT || frac_reg < DEC_LIMIT)
                        begin
                            if (prod > PROD_BITS'(VALUE_MAX))
                            begin
                                acc_next = VALUE_MAX;
                                sat_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = prod[VALUE_BITS-1:0];
                            end
                            if (mode_reg == MODE_REAL)
                                frac_next = frac_reg + 1'b1;
                        end
                        if (tlen_reg != LEN_MAX)
                            tlen_next = tlen_reg + 1'b1;
                    end
                    else if (mode_reg == MODE_INT && c == CH_POINT)
                    begin
                        mode_next = MODE_REAL;
                        if (tlen_reg != LEN_MAX)
                            tlen_next = tlen_reg + 1'b1;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                default:
                begin
                    do_begin = 1'b1;
                end
            endcase
        end

        if (do_flush)
            mode_next = MODE_IDLE;

        if (do_begin)
        begin
            mode_next = MODE_IDLE;
            if (c == CH_NEWLINE)
            begin
                lines_next = lines_reg + 1'b1;
            end
            else if (c != CH_SPACE && c != CH_TAB)
            begin
                tstart_next = pos_reg;
                tline_next  = lines_reg;
                if (is_op_start(c))
                begin
                    mode_next = MODE_OP;
                    pend_next = c;
                end
                else if (is_digit(c))
                begin
                    mode_next = MODE_INT;
                    acc_next  = VALUE_BITS'(c - CH_ZERO);
                    sat_next  = 1'b0;
                    frac_next = '0;
                    tlen_next = LEN_BITS'(1);
                end
                else
                begin
                    char_has              = 1'b1;
                    char_tok.kind         = KIND_CHAR;
                    char_tok.char_code    = c;
                    char_tok.start_offset = pos_reg;
                    char_tok.length       = LEN_BITS'(1);
                    char_tok.line         = lines_reg;
                end
            end
        end

        // pack the tokens of this word into two slots, flush first
        if (do_flush && flush_has)
        begin
            tok0  = flush_tok;
            n_tok = 2'd1;
            if (char_has)
            begin
                tok1  = char_tok;
                n_tok = 2'd2;
            end
        end
        else if (char_has)
        begin
            tok0  = char_tok;
            n_tok = 2'd1;
        end
        tok0.last = (n_tok == 2'd1);
        tok1.last = (n_tok == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= '0;
            pos_reg    <= '0;
            lines_reg  <= '0;
            tstart_reg <= '0;
            tline_reg  <= '0;
            acc_reg    <= '0;
            frac_reg   <= '0;
            sat_reg    <= 1'b0;
            tlen_reg   <= '0;
        end
        else if (in_fire)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            pos_reg    <= pos_next;
            lines_reg  <= lines_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            acc_reg    <= acc_next;
            frac_reg   <= frac_next;
            sat_reg    <= sat_next;
            tlen_reg   <= tlen_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_fire && n_tok != 2'd0)
            q_reg[wr_ptr_reg] <= tok0;
        if (in_fire && n_tok == 2'd2)
            q_reg[wr_ptr_reg + 1'b1] <= tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_fire)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(n_tok);
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (in_fire ? QCNT_BITS'(n_tok) : '0)
                               - QCNT_BITS'(out_fire);
        end
    end

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {3'b000, head.line, head.length, head.start_offset,
                       head.overflow, head.decimal_places, head.value,
                       head.char_code};

    // queue never overfills
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_BITS'(QDEPTH))
        else $error("result queue count beyond depth");

    // a pending number always has a length
    a_num_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_INT || mode_reg == MODE_REAL) |-> tlen_reg != '0)
        else $error("pending number with zero length");

    // kept fraction digits stay within the limit
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frac_reg <= DEC_LIMIT)
        else $error("fraction count beyond limit");

    // end of input does not move the byte position
    a_eoi_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && eoi) |=> $stable(pos_reg))
        else $error("byte position moved on end of input");

    // end of input leaves the scanner idle
    a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && eoi) |=> mode_reg == MODE_IDLE)
        else $error("token still pending after end of input");

endmodule
